@@ hw/rtl/rmst_pkg.sv @@
// Shared types and constants for the range maximum segment tree.
// No dependencies; used by rmst_node_ram, rmst_seq and range_max_segment_tree.
`default_nettype none

package rmst_pkg;

  // Fixed field widths
  localparam int unsigned ValW = 63;
  localparam int unsigned PosW = 10;
  localparam int unsigned EndW = 11;
  localparam int unsigned CfgW = 11;

  // Reset value of the leaf count register
  localparam logic [CfgW-1:0] CfgReset = 11'd1024;

  // Operation codes carried in tuser
  typedef enum logic {
    CmdUpdate = 1'b0,
    CmdQuery  = 1'b1
  } cmd_e;

  // One input transaction, unpacked
  typedef struct packed {
    cmd_e            cmd;
    logic [PosW-1:0] position;
    logic [EndW-1:0] right_end;
    logic [ValW-1:0] new_value;
  } item_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic ready;      // idle, can take a transaction
    logic res_valid;  // query result is on res_data
  } seq_stat_t;

endpackage : rmst_pkg

`default_nettype wire

@@ hw/rtl/rmst_node_ram.sv @@
// Node storage of the segment tree: one write port, one read port,
// registered read data. Depends on rmst_pkg for the value width.
`default_nettype none

module rmst_node_ram #(
  parameter int unsigned DEPTH = 2048
) (
  input  wire                           clk_i,
  input  wire                           we_i,
  input  wire  [$clog2(DEPTH)-1:0]      waddr_i,
  input  wire  [rmst_pkg::ValW-1:0]     wdata_i,
  input  wire  [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [rmst_pkg::ValW-1:0]     rdata_o
);

  logic [rmst_pkg::ValW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule : rmst_node_ram

`default_nettype wire

@@ hw/rtl/rmst_seq.sv @@
// Sequencer of the segment tree: clearing pass, plus update walk and query walk
// sharing one max comparator. Depends on rmst_pkg, rmst_node_ram.
`default_nettype none

module rmst_seq #(
  parameter int unsigned LEAVES = 1024
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  rmst_pkg::item_t                  item_i,
  input  wire  [$clog2(LEAVES+1)-1:0]      n_i,
  input  wire                              res_ready_i,
  output rmst_pkg::seq_stat_t              stat_o,
  output logic [rmst_pkg::ValW-1:0]        res_data_o
);

  localparam int unsigned Depth = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned KW    = AW + 1;
  localparam logic [AW-1:0] LastNode = AW'(Depth - 1);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StUpRd,
    StUpWr,
    StQLo,
    StQHi,
    StQDone
  } state_e;

  state_e state_q, state_d;
  logic [KW-1:0] k_q, k_d;    // node index (update) or lower bound (query)
  logic [KW-1:0] hi_q, hi_d;  // upper bound (query)
  logic [rmst_pkg::ValW-1:0] best_q, best_d;
  logic pend_q, pend_d;       // read data due this cycle
  logic [AW-1:0] clr_q, clr_d;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [rmst_pkg::ValW-1:0] wdata;
  logic [AW-1:0]             raddr;
  logic [rmst_pkg::ValW-1:0] rdata;

  logic [rmst_pkg::ValW-1:0] max_y;
  logic [31:0]               hi0_w;
  logic [KW-1:0]             k_half;

  rmst_node_ram #(
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared max unit
  assign max_y = (rdata > best_q) ? rdata : best_q;

  // Clamped right bound
  assign hi0_w = (32'(item_i.right_end) < 32'(n_i)) ? 32'(item_i.right_end) : 32'(n_i);

  assign k_half = k_q >> 1;

  assign stat_o.ready     = (state_q == StIdle);
  assign stat_o.res_valid = (state_q == StQDone);
  assign res_data_o       = best_q;

  // Next state and memory control
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    hi_d    = hi_q;
    best_d  = best_q;
    pend_d  = pend_q;
    clr_d   = clr_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr   = '0;

    case (state_q)
      StClear: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == LastNode) begin
          state_d = StIdle;
        end
      end

      StIdle: begin
        if (start_i) begin
          if (item_i.cmd == rmst_pkg::CmdUpdate) begin
            if (32'(item_i.position) < 32'(n_i)) begin
              k_d    = KW'(32'(item_i.position) + 32'(n_i));
              best_d = item_i.new_value;
              we     = 1'b1;
              waddr  = k_d[AW-1:0];
              wdata  = item_i.new_value;
              if (k_d > KW'(1)) begin
                state_d = StUpRd;
              end
            end
          end else begin
            best_d = '0;
            pend_d = 1'b0;
            if (32'(item_i.position) < hi0_w) begin
              k_d  = KW'(32'(item_i.position) + 32'(n_i));
              hi_d = KW'(hi0_w + 32'(n_i));
            end else begin
              k_d  = '0;
              hi_d = '0;
            end
            state_d = StQLo;
          end
        end
      end

      // Fetch the sibling
      StUpRd: begin
        raddr   = k_q[AW-1:0] ^ AW'(1);
        state_d = StUpWr;
      end

      // Parent gets the larger of the pair
      StUpWr: begin
        best_d = max_y;
        we     = 1'b1;
        waddr  = k_half[AW-1:0];
        wdata  = max_y;
        k_d    = k_half;
        if (k_half > KW'(1)) begin
          state_d = StUpRd;
        end else begin
          state_d = StIdle;
        end
      end

      // Left edge of the current level
      StQLo: begin
        if (pend_q) begin
          best_d = max_y;
        end
        pend_d = 1'b0;
        if (k_q < hi_q) begin
          if (k_q[0]) begin
            raddr  = k_q[AW-1:0];
            pend_d = 1'b1;
            k_d    = k_q + KW'(1);
          end
          state_d = StQHi;
        end else begin
          state_d = StQDone;
        end
      end

      // Right edge, then climb one level
      StQHi: begin
        if (pend_q) begin
          best_d = max_y;
        end
        pend_d = 1'b0;
        if (hi_q[0]) begin
          raddr  = AW'(hi_q - KW'(1));
          pend_d = 1'b1;
        end
        k_d     = k_half;
        hi_d    = hi_q >> 1;
        state_d = StQLo;
      end

      StQDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      k_q     <= '0;
      hi_q    <= '0;
      best_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      k_q     <= k_d;
      hi_q    <= hi_d;
      best_q  <= best_d;
    end
  end

endmodule : rmst_seq

`default_nettype wire

@@ hw/rtl/range_max_segment_tree.sv @@
// Top level of the range maximum segment tree: stream ports, leaf count
// register, output register. Depends on rmst_pkg and rmst_seq.
//
// Channel    Dir  Handshake                  Payload
// s_axis     in   s_axis_tvalid/tready       tuser: cmd; tdata: position,
//                                            right_end, new_value
// m_axis     out  m_axis_tvalid/tready       tdata: range_maximum
// cfg        in   cfg_we_i (no wait)         cfg_wdata_i: leaves_in_use
//
// After reset a clearing pass writes zero to all 2*LEAVES nodes, one per
// cycle; s_axis_tready stays low until the pass is done.
// An update writes the leaf, then does one sibling read and one parent write per
// level through the single RAM read port. A query checks a left and a right edge
// per tree level walked, also through that port.
// A finished query waits in the output register; a second result stalls the
// sequencer only while that register is still full.
`default_nettype none

module range_max_segment_tree #(
  parameter int unsigned LEAVES = 1024
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [87:0]                       s_axis_tdata,  // position, right_end, new_value
  input  wire  [0:0]                        s_axis_tuser,  // cmd
  // output stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [63:0]                       m_axis_tdata,  // range_maximum
  // leaf count register
  input  wire                               cfg_we_i,
  input  wire  [rmst_pkg::CfgW-1:0]         cfg_wdata_i
);

  localparam int unsigned NW = $clog2(LEAVES + 1);

  logic [rmst_pkg::CfgW-1:0] cfg_q;
  logic [NW-1:0]             n_eff;
  rmst_pkg::item_t           item;
  rmst_pkg::seq_stat_t       stat;
  logic                      start;
  logic                      res_ready;
  logic [rmst_pkg::ValW-1:0] res_data;
  logic                      out_valid_q;
  logic [rmst_pkg::ValW-1:0] out_data_q;

  // Leaf count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= rmst_pkg::CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Effective leaf count, capped at capacity
  assign n_eff = (32'(cfg_q) > 32'(LEAVES)) ? NW'(LEAVES) : NW'(cfg_q);

  // Unpack the input transaction
  assign item.cmd       = rmst_pkg::cmd_e'(s_axis_tuser[0]);
  assign item.position  = s_axis_tdata[9:0];
  assign item.right_end = s_axis_tdata[20:10];
  assign item.new_value = s_axis_tdata[83:21];

  assign s_axis_tready = stat.ready;
  assign start         = s_axis_tvalid & stat.ready;
  assign res_ready     = ~out_valid_q | m_axis_tready;

  rmst_seq #(
    .LEAVES (LEAVES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .n_i         (n_eff),
    .res_ready_i (res_ready),
    .stat_o      (stat),
    .res_data_o  (res_data)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

endmodule : range_max_segment_tree

`default_nettype wire
